// ===== design/bqs_pkg.sv =====
// shared types, codes and quorum arithmetic for the broadcast quorum session
`timescale 1ns / 1ps
`default_nettype none
package bqs_pkg;

  // field widths
  localparam int NODE_W     = 7;
  localparam int SID_W      = 6;
  localparam int OP_W       = 2;
  localparam int ACT_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // node limits
  localparam int                MAX_NODES_DEF  = 64;
  localparam logic [NODE_W-1:0] MIN_NODES      = 7'd4;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd4;

  // register byte addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_NODE_COUNT = 3'd0;

  // message codes
  localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_ECHO  = 2'd1;
  localparam logic [OP_W-1:0] OP_READY = 2'd2;

  // result codes
  localparam logic [ACT_W-1:0] ACT_ECHO    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READY   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELIVER = 2'd2;

  // classified message kinds
  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_ECHO  = 2'd1,
    KIND_READY = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SID_W-1:0]   sender;
  } cmd_t;

  // thresholds derived from the node count
  typedef struct packed {
    logic [NODE_W-1:0] t;
    logic [NODE_W-1:0] t2;
    logic [NODE_W-1:0] target;
  } quorum_t;

  // clamp n, then t = n/3 (minus one on exact multiples), echo target ceil((n+t+1)/2)
  function automatic quorum_t quorum_of(input logic [NODE_W-1:0] raw,
                                        input logic [NODE_W-1:0] max_n);
    logic [NODE_W-1:0] n;
    logic [14:0]       prod;
    logic [NODE_W-1:0] q;
    logic [NODE_W:0]   q3;
    logic [NODE_W:0]   s;
    quorum_t           r;
    n = raw;
    if (n < MIN_NODES) n = MIN_NODES;
    if (n > max_n) n = max_n;
    // divide by 3 through the reciprocal 171/512, exact for n below 128
    prod = 15'(n) * 15'd171;
    q    = NODE_W'(prod >> 9);
    q3   = ({1'b0, q} << 1) + {1'b0, q};
    if (q3 == {1'b0, n}) q = q - 7'd1;
    r.t      = q;
    r.t2     = {q[NODE_W-2:0], 1'b0};
    s        = {1'b0, n} + {1'b0, q} + 8'd1;
    r.target = NODE_W'((s >> 1) + (NODE_W+1)'(s[0]));
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/bqs_msg_if.sv =====
// message channel: op and sender number with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface bqs_msg_if;
  logic                       valid;
  logic                       ready;
  logic [bqs_pkg::OP_W-1:0]   op;
  logic [bqs_pkg::SID_W-1:0]  sender_id;

  modport source (output valid, op, sender_id, input ready);
  modport sink   (input valid, op, sender_id, output ready);
endinterface
`default_nettype wire

// ===== design/bqs_act_if.sv =====
// result channel: action and last flag with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface bqs_act_if;
  logic                       valid;
  logic                       ready;
  logic [bqs_pkg::ACT_W-1:0]  action;
  logic                       last;

  modport source (output valid, action, last, input ready);
  modport sink   (input valid, action, last, output ready);
endinterface
`default_nettype wire

// ===== design/bqs_front.sv =====
// front end: accepts messages, drops ones with no effect, queues the rest
`timescale 1ns / 1ps
`default_nettype none
module bqs_front #(
  parameter int MAX_NODES = bqs_pkg::MAX_NODES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  bqs_msg_if.sink            msg,
  output bqs_pkg::cmd_t      head,
  output logic               head_valid,
  input  wire logic          pop
);

  bqs_pkg::cmd_t  slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           vote_ok;
  logic           keep;
  bqs_pkg::cmd_t  cmd;
  logic           push;
  logic           do_pop;

  // classify the incoming word
  always_comb begin
    vote_ok    = {1'b0, msg.sender_id} < (bqs_pkg::SID_W+1)'(MAX_NODES);
    cmd.sender = msg.sender_id;
    cmd.kind   = bqs_pkg::KIND_SEND;
    keep       = 1'b0;
    unique case (msg.op)
      bqs_pkg::OP_SEND: begin
        cmd.kind = bqs_pkg::KIND_SEND;
        keep     = 1'b1;
      end
      bqs_pkg::OP_ECHO: begin
        cmd.kind = bqs_pkg::KIND_ECHO;
        keep     = vote_ok;
      end
      bqs_pkg::OP_READY: begin
        cmd.kind = bqs_pkg::KIND_READY;
        keep     = vote_ok;
      end
      default: keep = 1'b0;
    endcase
  end

  assign msg.ready  = (count != 2'd2);
  assign push       = msg.valid && msg.ready && keep;
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];
  assign do_pop     = pop && head_valid;

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (push && !do_pop) count <= count + 2'd1;
      else if (!push && do_pop) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== design/bqs_back.sv =====
// back end: vote bitmaps, quorum checks and the result buffer
`timescale 1ns / 1ps
`default_nettype none
module bqs_back #(
  parameter int MAX_NODES = bqs_pkg::MAX_NODES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bqs_pkg::cmd_t   head,
  input  wire logic            head_valid,
  output logic                 pop,
  input  wire bqs_pkg::quorum_t quorum,
  bqs_act_if.source            act
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  // session state
  logic [MAX_NODES-1:0] echo_map, echo_map_next;
  logic [MAX_NODES-1:0] ready_map, ready_map_next;
  logic [CNT_W-1:0]     echo_cnt, echo_cnt_next;
  logic [CNT_W-1:0]     ready_cnt, ready_cnt_next;
  logic                 have_msg, have_msg_next;
  logic                 ready_sent, ready_sent_next;
  logic                 delivered, delivered_next;

  // result buffer
  logic [bqs_pkg::ACT_W-1:0] res [3];
  logic [1:0]                res_cnt;

  logic [IDX_W-1:0]          idx;
  logic                      e_new;
  logic                      r_new;
  logic [CNT_W-1:0]          echo_inc;
  logic [CNT_W-1:0]          ready_inc;
  logic                      emit_ready;
  logic                      emit_deliver;
  logic                      emit_echo;
  logic [bqs_pkg::ACT_W-1:0] list [3];
  logic [1:0]                k;

  // take the next word when the buffer drains this cycle
  assign pop = head_valid && ((res_cnt == 2'd0) || ((res_cnt == 2'd1) && act.ready));

  // state update and result list for the word at the queue head
  always_comb begin
    idx             = head.sender[IDX_W-1:0];
    e_new           = !echo_map[idx];
    r_new           = !ready_map[idx];
    echo_inc        = echo_cnt + CNT_W'(e_new);
    ready_inc       = ready_cnt + CNT_W'(r_new);
    echo_map_next   = echo_map;
    ready_map_next  = ready_map;
    echo_cnt_next   = echo_cnt;
    ready_cnt_next  = ready_cnt;
    have_msg_next   = have_msg;
    emit_ready      = 1'b0;
    emit_deliver    = 1'b0;
    emit_echo       = 1'b0;
    if (pop && !delivered) begin
      unique case (head.kind)
        bqs_pkg::KIND_SEND: begin
          emit_echo = 1'b1;
          if (!have_msg) begin
            have_msg_next = 1'b1;
            emit_ready    = !ready_sent &&
                            ((bqs_pkg::NODE_W'(echo_cnt) >= quorum.target) ||
                             (bqs_pkg::NODE_W'(ready_cnt) > quorum.t));
            emit_deliver  = bqs_pkg::NODE_W'(ready_cnt) > quorum.t2;
          end
        end
        bqs_pkg::KIND_ECHO: begin
          if (!have_msg || !ready_sent) begin
            echo_map_next[idx] = 1'b1;
            echo_cnt_next      = echo_inc;
          end
          if (have_msg && !ready_sent)
            emit_ready = bqs_pkg::NODE_W'(echo_inc) >= quorum.target;
        end
        bqs_pkg::KIND_READY: begin
          ready_map_next[idx] = 1'b1;
          ready_cnt_next      = ready_inc;
          if (have_msg) begin
            emit_ready   = !ready_sent && (bqs_pkg::NODE_W'(ready_inc) > quorum.t);
            emit_deliver = bqs_pkg::NODE_W'(ready_inc) > quorum.t2;
          end
        end
        default: ;
      endcase
    end
    ready_sent_next = ready_sent | emit_ready;
    delivered_next  = delivered | emit_deliver;

    // order: ready, deliver, echo
    list[0] = bqs_pkg::ACT_ECHO;
    list[1] = bqs_pkg::ACT_ECHO;
    list[2] = bqs_pkg::ACT_ECHO;
    k       = 2'd0;
    if (emit_ready) begin
      list[k] = bqs_pkg::ACT_READY;
      k       = k + 2'd1;
    end
    if (emit_deliver) begin
      list[k] = bqs_pkg::ACT_DELIVER;
      k       = k + 2'd1;
    end
    if (emit_echo) begin
      list[k] = bqs_pkg::ACT_ECHO;
      k       = k + 2'd1;
    end
  end

  // session registers and buffer fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_map   <= '0;
      ready_map  <= '0;
      echo_cnt   <= '0;
      ready_cnt  <= '0;
      have_msg   <= 1'b0;
      ready_sent <= 1'b0;
      delivered  <= 1'b0;
      res_cnt    <= 2'd0;
    end else begin
      echo_map   <= echo_map_next;
      ready_map  <= ready_map_next;
      echo_cnt   <= echo_cnt_next;
      ready_cnt  <= ready_cnt_next;
      have_msg   <= have_msg_next;
      ready_sent <= ready_sent_next;
      delivered  <= delivered_next;
      if (pop && (k != 2'd0)) res_cnt <= k;
      else if (act.valid && act.ready) res_cnt <= res_cnt - 2'd1;
    end
  end

  // buffer payload: load a new list or shift toward the output
  always_ff @(posedge clk) begin
    if (pop && (k != 2'd0)) begin
      res[0] <= list[0];
      res[1] <= list[1];
      res[2] <= list[2];
    end else if (act.valid && act.ready) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  assign act.valid  = (res_cnt != 2'd0);
  assign act.action = res[0];
  assign act.last   = (res_cnt == 2'd1);

endmodule
`default_nettype wire

// ===== design/broadcast_quorum_session.sv =====
// top level: configuration registers, front end queue and back end
//
// Usage: protocol messages (op, sender_id) enter on msg; results (action, last)
// leave on act, the final result of each message marked by last. Messages
// with an unknown op, votes from senders at or above MAX_NODES and every
// message after delivery produce no result. node_count sits at byte address 0
// of the APB port; the fault limit and echo quorum are derived when it is
// written, so write it only while no message is in flight.
// Path: an accepted msg word is written into the front end queue, and its
// results are registered in the back end result buffer before they reach act.
// Throughput: one message per cycle while each gives at most one result and
// act is ready; a message with more results holds the back end until the
// output buffer has sent them all, one result word per cycle while act is
// ready. While a stalled act receiver holds the back end, the two-entry queue
// takes up to two more words; msg ready then stays low until the back end takes
// the next word. Reset clears all vote bitmaps and flags and sets node_count
// to 4; msg is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module broadcast_quorum_session #(
  parameter int MAX_NODES = bqs_pkg::MAX_NODES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bqs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bqs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [bqs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  bqs_msg_if.sink                              msg,
  bqs_act_if.source                            act
);

  logic [bqs_pkg::NODE_W-1:0] node_count;
  bqs_pkg::quorum_t           quorum;
  logic                       cfg_wr;
  bqs_pkg::cmd_t              head;
  logic                       head_valid;
  logic                       pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == bqs_pkg::ADDR_NODE_COUNT);

  // node count register and derived thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= bqs_pkg::NODE_COUNT_RST;
      quorum     <= bqs_pkg::quorum_of(bqs_pkg::NODE_COUNT_RST,
                                       bqs_pkg::NODE_W'(MAX_NODES));
    end else if (cfg_wr) begin
      node_count <= pwdata[bqs_pkg::NODE_W-1:0];
      quorum     <= bqs_pkg::quorum_of(pwdata[bqs_pkg::NODE_W-1:0],
                                       bqs_pkg::NODE_W'(MAX_NODES));
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    if (paddr == bqs_pkg::ADDR_NODE_COUNT)
      prdata = bqs_pkg::CFG_DATA_W'(node_count);
  end

  bqs_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  bqs_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .quorum     (quorum),
    .act        (act)
  );

endmodule
`default_nettype wire

// ===== tb/sv/bqs_session_checker.sv =====
// session checker: predicts results from accepted message words and compares act words
`timescale 1ns / 1ps
`default_nettype none
module bqs_session_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bqs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bqs_pkg::CFG_DATA_W-1:0]  pwdata,
  input  wire logic [bqs_pkg::CFG_DATA_W-1:0]  prdata,
  input  wire logic                            pready,
  bqs_msg_if                                   msg,
  bqs_act_if                                   act,
  output int                                   errors,
  output int                                   pending,
  output int                                   results
);
  import bqs_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             last;
  } act_word_t;

  // shadow of the session state and the node count register
  logic [NODE_W-1:0] nodes_cfg;
  logic              msg_held;
  logic [63:0]       echo_map;
  logic [63:0]       ready_map;
  logic              ready_out;
  logic              delivered;
  act_word_t         expected_acts[$];
  int                fails = 0;
  int                pending_cnt = 0;
  int                checked = 0;

  assign errors  = fails;
  assign pending = pending_cnt;
  assign results = checked;

  // count a failure, print only the first few
  task automatic note_fault(input string text);
    fails++;
    if (fails <= 10) $display("%0t ns: %s", $time, text);
  endtask

  // fault bound t = n/3, one less on exact multiples of 3
  function automatic int unsigned fault_bound(input int unsigned n);
    int unsigned t;
    t = n / 3;
    if (t * 3 == n) t = t - 1;
    return t;
  endfunction

  // advance the session by one message word and queue the act words it causes
  task automatic tally_message(input logic [OP_W-1:0] op, input logic [SID_W-1:0] sid);
    int unsigned      n;
    int unsigned      t;
    int unsigned      goal;
    int unsigned      rc;
    logic [63:0]      sid_bit;
    logic [ACT_W-1:0] acts[$];
    act_word_t        w;
    n = nodes_cfg;
    if (n < MIN_NODES) n = MIN_NODES;
    if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
    t = fault_bound(n);
    goal = (n + t + 1) / 2 + (n + t + 1) % 2;
    sid_bit = 64'd1 << sid;
    if (delivered) return;
    case (op)
      OP_SEND: begin
        // first send evaluates the votes gathered so far
        if (!msg_held) begin
          msg_held = 1'b1;
          rc = $countones(ready_map);
          if (!ready_out && ($countones(echo_map) >= goal || rc > t)) begin
            ready_out = 1'b1;
            acts.push_back(ACT_READY);
          end
          if (rc > 2 * t) begin
            delivered = 1'b1;
            acts.push_back(ACT_DELIVER);
          end
        end
        acts.push_back(ACT_ECHO);
      end
      OP_ECHO: begin
        if (int'(sid) < MAX_NODES_DEF) begin
          if (!msg_held) begin
            echo_map |= sid_bit;
          end else if (!ready_out) begin
            echo_map |= sid_bit;
            if ($countones(echo_map) >= goal) begin
              ready_out = 1'b1;
              acts.push_back(ACT_READY);
            end
          end
        end
      end
      OP_READY: begin
        if (int'(sid) < MAX_NODES_DEF) begin
          ready_map |= sid_bit;
          if (msg_held) begin
            rc = $countones(ready_map);
            if (!ready_out && rc > t) begin
              ready_out = 1'b1;
              acts.push_back(ACT_READY);
            end
            if (rc > 2 * t) begin
              delivered = 1'b1;
              acts.push_back(ACT_DELIVER);
            end
          end
        end
      end
      default: ;
    endcase
    foreach (acts[i]) begin
      w.action = acts[i];
      w.last   = (i == acts.size() - 1);
      expected_acts.push_back(w);
    end
  endtask

  // sample everything at the rising edge
  always @(posedge clk) begin : watch
    act_word_t want;
    if (rst) begin
      nodes_cfg = NODE_COUNT_RST;
      msg_held  = 1'b0;
      echo_map  = '0;
      ready_map = '0;
      ready_out = 1'b0;
      delivered = 1'b0;
      expected_acts.delete();
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready && paddr == ADDR_NODE_COUNT) begin
        if (pwrite) begin
          nodes_cfg = pwdata[NODE_W-1:0];
        end else if (prdata !== CFG_DATA_W'(nodes_cfg)) begin
          note_fault($sformatf("node_count read: expected %0d, got %0d", nodes_cfg, prdata));
        end
      end
      // result words against the oldest expectation
      if (act.valid && act.ready) begin
        checked++;
        if (expected_acts.size() == 0) begin
          note_fault($sformatf("act word (action %0d, last %0b) with nothing expected",
                               act.action, act.last));
        end else begin
          want = expected_acts.pop_front();
          if (act.action !== want.action)
            note_fault($sformatf("action: expected %0d, got %0d", want.action, act.action));
          if (act.last !== want.last)
            note_fault($sformatf("last: expected %0b, got %0b", want.last, act.last));
        end
      end
      // message words feed the predictor
      if (msg.valid && msg.ready) tally_message(msg.op, msg.sender_id);
    end
    pending_cnt = expected_acts.size();
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// top of the testbench: clock, reset, stimulus, register writes and the verdict
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import bqs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 60;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TAIL_CYCLES    = 20;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // how the single ready of the session gets triggered
  typedef enum int {
    PATH_AT_SEND,
    PATH_ECHO_QUORUM,
    PATH_READY_COUNT,
    PATH_READY_DELIVER
  } path_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;
  int                    results;
  int                    words_sent = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    quiet_cycles = 0;
  bit                    burst = 1'b0;
  bit                    hold_req = 1'b0;
  path_t                 path;

  bqs_msg_if msg();
  bqs_act_if act();

  broadcast_quorum_session dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .msg     (msg),
    .act     (act)
  );

  bqs_session_checker session_chk (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .msg     (msg),
    .act     (act),
    .errors  (errors),
    .pending (pending),
    .results (results)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // act receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    act.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        act.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        act.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (msg.valid && msg.ready) || (act.valid && act.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one message word, called and returning at a falling edge
  task automatic put_word(input logic [OP_W-1:0] op, input logic [SID_W-1:0] sid);
    if (words_sent < 115) begin
      send_idle_pct = 22;
      recv_idle_pct = 85;
    end else if (words_sent < 230) begin
      send_idle_pct = 85;
      recv_idle_pct = 22;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while (!burst && $urandom_range(99) < send_idle_pct) begin
      msg.valid <= 1'b0;
      @(negedge clk);
    end
    msg.valid     <= 1'b1;
    msg.op        <= op;
    msg.sender_id <= sid;
    do @(posedge clk); while (!msg.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // random word while the session is live; vote pools stay below every quorum at n = 64
  task automatic live_word();
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(99);
    if (pick < 30) begin
      put_word(OP_SEND, SID_W'($urandom));
    end else if (pick < 65) begin
      r = $urandom_range(41);
      put_word(OP_ECHO, (r == 41) ? SID_W'(63) : SID_W'(r));
    end else if (pick < 95) begin
      r = $urandom_range(20);
      put_word(OP_READY, (r == 20) ? SID_W'(63) : SID_W'(r));
    end else begin
      put_word(OP_UNUSED, SID_W'($urandom));
    end
  endtask

  // stop offering until every expected result is back and the queue has drained
  task automatic pause_words();
    msg.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write node_count, then read it back for the checker
  task automatic set_node_count(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NODE_COUNT;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    msg.valid     = 1'b0;
    msg.op        = OP_SEND;
    msg.sender_id = '0;
    path          = path_t'($urandom_range(3));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: below-range node count, ignored ops, votes recorded ahead of the send
    set_node_count(0);
    put_word(OP_UNUSED, SID_W'(0));
    put_word(OP_UNUSED, SID_W'(63));
    put_word(OP_ECHO, SID_W'(63));
    put_word(OP_ECHO, SID_W'(0));
    put_word(OP_READY, SID_W'(63));
    if (path == PATH_AT_SEND) put_word(OP_READY, SID_W'(0));
    put_word(OP_SEND, SID_W'(0));
    put_word(OP_SEND, SID_W'(63));
    pause_words();

    // directed: above-range node count, duplicate votes, repeated sends
    set_node_count(127);
    put_word(OP_READY, SID_W'(0));
    put_word(OP_ECHO, SID_W'(0));
    put_word(OP_SEND, SID_W'(42));
    put_word(OP_ECHO, SID_W'(21));
    put_word(OP_READY, SID_W'(19));

    // random live session, with one long act hold-off under a burst of sends
    for (int i = 0; i < 200; i++) begin
      if (i == 60) begin
        hold_req = 1'b1;
        burst    = 1'b1;
        repeat (12) put_word(OP_SEND, SID_W'($urandom));
        burst    = 1'b0;
      end
      live_word();
    end

    // trigger the ready along the chosen path
    case (path)
      PATH_ECHO_QUORUM: begin
        for (int s = 1; s < 63; s++) put_word(OP_ECHO, SID_W'(s));
      end
      PATH_READY_COUNT: begin
        for (int s = 20; s <= 40; s++) put_word(OP_READY, SID_W'(s));
      end
      PATH_READY_DELIVER: begin
        pause_words();
        set_node_count($urandom_range(3));
        put_word(OP_READY, SID_W'(62));
      end
      default: ;
    endcase

    // after the ready: echo votes are dropped, readies pile up unless delivered
    for (int i = 0; i < 30; i++) live_word();

    // delivery under a random node count, then words after delivery
    pause_words();
    set_node_count($urandom_range(4, 127));
    for (int s = 0; s < 63; s++) put_word(OP_READY, SID_W'(s));
    put_word(OP_SEND, SID_W'(63));
    put_word(OP_ECHO, SID_W'(5));
    put_word(OP_READY, SID_W'(63));

    // drain and give the verdict
    msg.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("run covered %0d message words and %0d result words, ready via %s",
             words_sent, results, path.name());
    $display("node counts written: below range, above range and one random value");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
